>>> rtl/ecd_pkg.sv
// Package for the elevator call dispatcher: status codes, headings, sequencer states.
// No dependencies.
package ecd_pkg;

    localparam logic [2:0] ST_ASSIGNED = 3'd0;
    localparam logic [2:0] ST_UP_WAIT  = 3'd1;
    localparam logic [2:0] ST_DN_WAIT  = 3'd2;
    localparam logic [2:0] ST_DROPPED  = 3'd3;
    localparam logic [2:0] ST_REPORT   = 3'd4;

    localparam logic signed [1:0] HEAD_UP   = 2'sb01;
    localparam logic signed [1:0] HEAD_IDLE = 2'sb00;
    localparam logic signed [1:0] HEAD_DOWN = 2'sb11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_MOVE,   // scan cars for one moving the call's way
        S_ADD_IDLE,   // scan cars for an idle one
        S_ADD_DONE,
        S_STEP_CAR,   // per car: move, go idle, or decide on a wait pair
        S_SCAN_MAP,   // scan wait rows for the extreme pair
        S_TAKE,       // apply taken pair to the car
        S_ABSORB,     // absorb one wait row per cycle
        S_REPORT
    } state_t;

endpackage

>>> rtl/elevator_call_dispatcher.sv
// Elevator call dispatcher top level: car state, wait maps and the sequencer.
// Depends on ecd_pkg.
//
// Usage: raise start for one cycle with operation, from_floor, to_floor while
// busy is low; the transaction is taken at that edge and busy rises.
// An add transaction gives one result; a step transaction gives NUM_ELEVATORS
// car reports. Each result shows for one cycle under strobe; last marks the
// final one, and busy falls the cycle after it, so the next transaction can be
// taken in the cycle after the last result.
// An add first scans the cars for one moving the call's way and, if none is
// found, scans them for an idle car, then shows its result. Step handles each
// car in turn: it moves or goes idle, or, if it takes a wait pair, it passes a
// decide state, a scan of the wait rows, a take state and, for a moving pair, an
// absorb pass over the wait rows. Then one report per car follows. A single
// shared row-scan index walks both the cars and the wait map rows.
// Reset clears all calls and waits, sets every car idle on floor 1.
// The receiver cannot stall; results are never held.
// Wait maps are flip-flop rows read at the scan index; all rows are ORed for the any-wait flags.
module elevator_call_dispatcher
    import ecd_pkg::*;
#(
    parameter int NUM_FLOORS    = 16,
    parameter int NUM_ELEVATORS = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [4:0]        from_floor,
    input  logic [4:0]        to_floor,
    output logic              strobe,
    output logic [2:0]        status,
    output logic [2:0]        car_index,
    output logic [4:0]        car_floor,
    output logic signed [1:0] car_heading,
    output logic              last
);

    localparam int FW = $clog2(NUM_FLOORS + 1);
    localparam int RW = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam int CW = (NUM_ELEVATORS > 1) ? $clog2(NUM_ELEVATORS) : 1;
    localparam int IW = (RW > CW) ? RW : CW;
    localparam logic [FW-1:0] TOP = FW'(NUM_FLOORS);

    state_t state_reg, state_next;

    logic [NUM_FLOORS-1:0] pend_reg [NUM_ELEVATORS];
    logic signed [1:0]     head_reg [NUM_ELEVATORS];
    logic [FW-1:0]         pos_reg  [NUM_ELEVATORS];
    logic [NUM_FLOORS-1:0] upw_reg  [NUM_FLOORS];
    logic [NUM_FLOORS-1:0] dnw_reg  [NUM_FLOORS];

    logic [FW-1:0]     from_reg, to_reg;
    logic signed [1:0] way_reg;
    logic [IW:0]       idx_reg;   // shared scan index, one spare bit for end test
    logic [CW-1:0]     car_reg;
    logic              use_up_reg;
    logic [2:0]        res_st_reg;
    logic [CW-1:0]     res_car_reg;

    // input clamp
    function automatic logic [FW-1:0] clampf(input logic [4:0] f);
        if (f == 5'd0) return FW'(1);
        if ({2'b0, f} > 7'(NUM_FLOORS)) return TOP;
        return FW'(f);
    endfunction

    function automatic logic [NUM_FLOORS-1:0] fbit(input logic [FW-1:0] f);
        logic [NUM_FLOORS-1:0] b;
        b = '0;
        b[RW'(f - FW'(1))] = 1'b1;
        return b;
    endfunction

    function automatic logic [FW-1:0] lowest(input logic [NUM_FLOORS-1:0] r);
        logic [FW-1:0] v;
        v = FW'(1);
        for (int i = NUM_FLOORS - 1; i >= 0; i--)
            if (r[i]) v = FW'(i + 1);
        return v;
    endfunction

    logic [FW-1:0] cfrom, cto;
    logic signed [1:0] cway;
    assign cfrom = clampf(from_floor);
    assign cto   = clampf(to_floor);
    assign cway  = (cfrom < cto) ? HEAD_UP : (cfrom > cto) ? HEAD_DOWN : HEAD_IDLE;

    logic up_has, dn_has;
    always_comb
    begin
        up_has = 1'b0;
        dn_has = 1'b0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            up_has = up_has | (|upw_reg[i]);
            dn_has = dn_has | (|dnw_reg[i]);
        end
    end

    logic [CW-1:0] ci;
    logic [RW-1:0] ri, mrow;
    logic          last_car, last_row;
    assign ci = CW'(idx_reg);
    assign ri = RW'(idx_reg);
    assign last_car = (idx_reg == (IW+1)'(NUM_ELEVATORS - 1));
    assign last_row = (idx_reg == (IW+1)'(NUM_FLOORS - 1));
    // down pairs scan from the top floor
    assign mrow = use_up_reg ? ri : RW'(NUM_FLOORS - 1) - ri;

    logic [NUM_FLOORS-1:0] srow;
    assign srow = use_up_reg ? upw_reg[mrow] : dnw_reg[mrow];

    logic move_hit, idle_hit;
    assign move_hit = (head_reg[ci] == HEAD_UP && way_reg == HEAD_UP && pos_reg[ci] <= from_reg)
        || (head_reg[ci] == HEAD_DOWN && way_reg == HEAD_DOWN && pos_reg[ci] >= from_reg);
    assign idle_hit = (head_reg[ci] == HEAD_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = operation ? S_STEP_CAR : S_ADD_MOVE;
            S_ADD_MOVE:
                if (move_hit)
                    state_next = S_ADD_DONE;
                else if (last_car)
                    state_next = S_ADD_IDLE;
            S_ADD_IDLE:
                if (idle_hit || last_car)
                    state_next = S_ADD_DONE;
            S_ADD_DONE:
                state_next = S_IDLE;
            S_STEP_CAR:
                if (pend_reg[car_reg] == '0 && (up_has || dn_has))
                    state_next = S_SCAN_MAP;
                else if (car_reg == CW'(NUM_ELEVATORS - 1))
                    state_next = S_REPORT;
            S_SCAN_MAP:
                if (srow != '0)
                    state_next = S_TAKE;
            S_TAKE:
                if (way_reg != HEAD_IDLE)
                    state_next = S_ABSORB;
                else if (car_reg == CW'(NUM_ELEVATORS - 1))
                    state_next = S_REPORT;
                else
                    state_next = S_STEP_CAR;
            S_ABSORB:
                if (last_row)
                    state_next = (car_reg == CW'(NUM_ELEVATORS - 1)) ? S_REPORT : S_STEP_CAR;
            S_REPORT:
                if (last_car)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        strobe      = 1'b0;
        status      = res_st_reg;
        car_index   = 3'(res_car_reg);
        car_floor   = 5'(pos_reg[res_car_reg]);
        car_heading = head_reg[res_car_reg];
        last        = 1'b0;
        case (state_reg)
            S_ADD_DONE:
            begin
                strobe = 1'b1;
                last   = 1'b1;
                if (res_st_reg != ST_ASSIGNED)
                begin
                    car_index   = 3'd0;
                    car_floor   = 5'd0;
                    car_heading = HEAD_IDLE;
                end
            end
            S_REPORT:
            begin
                strobe      = 1'b1;
                status      = ST_REPORT;
                car_index   = 3'(ci);
                car_floor   = 5'(pos_reg[ci]);
                car_heading = head_reg[ci];
                last        = last_car;
            end
            default: ;
        endcase
    end

    logic [FW-1:0] stepped;
    always_comb
    begin
        stepped = pos_reg[car_reg];
        if (head_reg[car_reg] == HEAD_UP && pos_reg[car_reg] < TOP)
            stepped = pos_reg[car_reg] + FW'(1);
        else if (head_reg[car_reg] == HEAD_DOWN && pos_reg[car_reg] > FW'(1))
            stepped = pos_reg[car_reg] - FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int c = 0; c < NUM_ELEVATORS; c++)
            begin
                pend_reg[c] <= '0;
                head_reg[c] <= HEAD_IDLE;
                pos_reg[c]  <= FW'(1);
            end
            for (int f = 0; f < NUM_FLOORS; f++)
            begin
                upw_reg[f] <= '0;
                dnw_reg[f] <= '0;
            end
            idx_reg     <= '0;
            car_reg     <= '0;
            use_up_reg  <= 1'b0;
            res_st_reg  <= ST_ASSIGNED;
            res_car_reg <= '0;
            from_reg    <= FW'(1);
            to_reg      <= FW'(1);
            way_reg     <= HEAD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        from_reg <= cfrom;
                        to_reg   <= cto;
                        way_reg  <= cway;
                        idx_reg  <= '0;
                        car_reg  <= '0;
                    end
                S_ADD_MOVE:
                    if (move_hit)
                    begin
                        res_st_reg  <= ST_ASSIGNED;
                        res_car_reg <= ci;
                        if (pos_reg[ci] != from_reg)
                            pend_reg[ci] <= pend_reg[ci] | fbit(from_reg) | fbit(to_reg);
                        else
                            pend_reg[ci] <= pend_reg[ci] | fbit(to_reg);
                    end
                    else
                        idx_reg <= last_car ? '0 : idx_reg + 1'b1;
                S_ADD_IDLE:
                    if (idle_hit)
                    begin
                        res_st_reg   <= ST_ASSIGNED;
                        res_car_reg  <= ci;
                        pos_reg[ci]  <= from_reg;
                        head_reg[ci] <= way_reg;
                        pend_reg[ci] <= pend_reg[ci] | fbit(to_reg);
                    end
                    else if (last_car)
                    begin
                        res_car_reg <= '0;
                        if (way_reg == HEAD_UP)
                        begin
                            res_st_reg <= ST_UP_WAIT;
                            upw_reg[RW'(from_reg - FW'(1))] <=
                                upw_reg[RW'(from_reg - FW'(1))] | fbit(to_reg);
                        end
                        else if (way_reg == HEAD_DOWN)
                        begin
                            res_st_reg <= ST_DN_WAIT;
                            dnw_reg[RW'(from_reg - FW'(1))] <=
                                dnw_reg[RW'(from_reg - FW'(1))] | fbit(to_reg);
                        end
                        else
                            res_st_reg <= ST_DROPPED;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                S_STEP_CAR:
                begin
                    idx_reg <= '0;
                    if (pend_reg[car_reg] != '0)
                    begin
                        pos_reg[car_reg]  <= stepped;
                        pend_reg[car_reg] <= pend_reg[car_reg] & ~fbit(stepped);
                    end
                    else if (up_has || dn_has)
                    begin
                        if (head_reg[car_reg] == HEAD_DOWN)
                            use_up_reg <= up_has;
                        else
                            use_up_reg <= !dn_has;
                    end
                    else
                        head_reg[car_reg] <= HEAD_IDLE;
                    if (!(pend_reg[car_reg] == '0 && (up_has || dn_has)))
                        car_reg <= car_reg + 1'b1;
                end
                S_SCAN_MAP:
                    if (srow != '0)
                    begin
                        from_reg <= FW'(mrow) + FW'(1);
                        to_reg   <= lowest(srow);
                        if (use_up_reg)
                            upw_reg[mrow] <= srow & ~fbit(lowest(srow));
                        else
                            dnw_reg[mrow] <= srow & ~fbit(lowest(srow));
                        way_reg <= (FW'(mrow) + FW'(1) < lowest(srow)) ? HEAD_UP :
                            (FW'(mrow) + FW'(1) > lowest(srow)) ? HEAD_DOWN : HEAD_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                S_TAKE:
                begin
                    pend_reg[car_reg] <= pend_reg[car_reg] | fbit(to_reg);
                    pos_reg[car_reg]  <= from_reg;
                    head_reg[car_reg] <= way_reg;
                    idx_reg <= '0;
                    if (way_reg == HEAD_IDLE)
                        car_reg <= car_reg + 1'b1;
                end
                S_ABSORB:
                begin
                    if (way_reg == HEAD_UP && upw_reg[ri] != '0)
                    begin
                        pend_reg[car_reg] <= pend_reg[car_reg] | upw_reg[ri] |
                            ((pos_reg[car_reg] != FW'(ri) + FW'(1)) ?
                             fbit(FW'(ri) + FW'(1)) : '0);
                        upw_reg[ri] <= '0;
                    end
                    else if (way_reg == HEAD_DOWN && dnw_reg[ri] != '0)
                    begin
                        pend_reg[car_reg] <= pend_reg[car_reg] | dnw_reg[ri] |
                            ((pos_reg[car_reg] != FW'(ri) + FW'(1)) ?
                             fbit(FW'(ri) + FW'(1)) : '0);
                        dnw_reg[ri] <= '0;
                    end
                    if (last_row)
                    begin
                        idx_reg <= '0;
                        car_reg <= car_reg + 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_REPORT:
                    idx_reg <= idx_reg + 1'b1;
                default: ;
            endcase
        end
    end

endmodule
